// File: rtl/core/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types, constants and helpers of the soft brush dab tile blend core.
// ----------------------------------------------------------------------------
package sbd_pkg;

   // Tile geometry default and channel format (U0.16, ONE = 65535)
   localparam int          TILE_EDGE_DEF = 64;
   localparam int          CH_BITS       = 16;
   localparam logic [15:0] CH_ONE        = 16'hFFFF;
   localparam logic [15:0] CH_HALF       = 16'h7FFF;
   localparam logic [14:0] MIN_RADIUS    = 15'd26;

   // Shared divider geometry: 46-bit dividend, 30-bit divisor, 16 quotient bits
   localparam int DIV_NW = 46;
   localparam int DIV_DW = 30;
   localparam int DIV_QW = 16;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDOUT,
      ST_DY,
      ST_DX,
      ST_CHECK,
      ST_RRGO,
      ST_RRWAIT,
      ST_FALL,
      ST_FWAIT,
      ST_OPA,
      ST_OPA2,
      ST_MA,
      ST_MB,
      ST_MC,
      ST_WR,
      ST_DONE
   } state_type;

   // Rounded divide by ONE; y already holds the half-ONE rounding term, y < 2^33
   function automatic logic [15:0] div_one(input logic [32:0] y);
      logic [16:0] q0;
      logic [17:0] r;
      logic [16:0] q;
      q0 = y[32:16];
      r  = 18'(y[15:0]) + 18'(q0);
      if (r >= 18'd131070) begin
         q = q0 + 17'd2;
      end else if (r >= 18'd65535) begin
         q = q0 + 17'd1;
      end else begin
         q = q0;
      end
      return q[15:0];
   endfunction

endpackage

// File: rtl/core/sbd_tile_mem.sv
// ----------------------------------------------------------------------------
// sbd_tile_mem
// Tile pixel store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbd_tile_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/sbd_divider.sv
// ----------------------------------------------------------------------------
// sbd_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in DIV_QW bits (num < den << DIV_QW).
// ----------------------------------------------------------------------------
module sbd_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sbd_pkg::DIV_NW-1:0] num,
   input  logic [sbd_pkg::DIV_DW-1:0] den,
   output logic                       done,
   output logic [sbd_pkg::DIV_QW-1:0] quo
);
   import sbd_pkg::*;

   localparam int CW = $clog2(DIV_QW + 1);

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_QW-1:0] low_ff, low_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;

   // one shift-subtract step
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, low_ff[DIV_QW-1]};
      if (start) begin
         rem_in = num[DIV_NW-1:DIV_QW];
         low_in = num[DIV_QW-1:0];
         den_in = den;
         cnt_in = CW'(DIV_QW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DW'(trial - {1'b0, den_ff});
            low_in = {low_ff[DIV_QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            low_in = {low_ff[DIV_QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = low_ff;
endmodule

// File: rtl/core/soft_brush_dab_tile_blend_core.sv
// ----------------------------------------------------------------------------
// soft_brush_dab_tile_blend_core
// Soft round brush dab with over blend on one tile of premultiplied RGBA
// pixels held in a single-port-pair memory, plus single pixel reads.
// ----------------------------------------------------------------------------
//  channel   handshake             beat contents
//  request   start & !busy         req_kind, dab geometry/colour, pixel index
//  response  rsp_valid (1 cycle)   out colour/alpha, is_read_data
//
//  Reset clears the tile by writing every pixel in turn; busy is high
//  meanwhile. A dab visits every pixel in raster order, with an extra dy
//  step at each row start; a painted pixel takes two 16-step divider runs
//  (one with a hard edge) and four channel blends that share one
//  multiplier path. The response strobe cannot be stalled; a new beat may
//  be accepted in the cycle it is shown.
// ----------------------------------------------------------------------------
module soft_brush_dab_tile_blend_core #(
   parameter int TILE_EDGE = sbd_pkg::TILE_EDGE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic signed [16:0] req_center_x,
   input  logic signed [16:0] req_center_y,
   input  logic [14:0]        req_dab_radius,
   input  logic [15:0]        req_opacity,
   input  logic [15:0]        req_hardness,
   input  logic [15:0]        req_red,
   input  logic [15:0]        req_green,
   input  logic [15:0]        req_blue,
   input  logic [11:0]        req_pixel_index,
   output logic               rsp_valid,
   output logic [15:0]        rsp_out_red,
   output logic [15:0]        rsp_out_green,
   output logic [15:0]        rsp_out_blue,
   output logic [15:0]        rsp_out_alpha,
   output logic               rsp_is_read_data
);
   import sbd_pkg::*;

   localparam int NPIX = TILE_EDGE * TILE_EDGE;
   localparam int AW   = $clog2(NPIX);
   localparam int XW   = $clog2(TILE_EDGE);

   state_type state_ff, state_in;

   // item registers
   logic signed [16:0] cx_ff, cy_ff;
   logic [29:0]        r2_ff;
   logic [15:0]        op_ff, h_ff;
   logic [15:0]        top_ff [4];
   logic [XW-1:0]      x_ff;
   logic [XW-1:0]      y_ff;
   logic [AW-1:0]      idx_ff;
   logic [35:0]        dy2_ff, dx2_ff;
   logic [29:0]        d2_ff;
   logic [15:0]        rr_ff, o_ff, opa_ff;
   logic               fa_ff;
   logic [32:0]        acc_ff;
   logic [1:0]         k_ff;
   logic [15:0]        chan_ff [4];
   logic               rd_ok_ff;

   // response registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_r_ff, rsp_g_ff, rsp_b_ff, rsp_a_ff;
   logic [15:0] rsp_r_in, rsp_g_in, rsp_b_in, rsp_a_in;
   logic        rsp_rd_ff, rsp_rd_in;

   // memory and divider hookup
   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [63:0]   mem_wr_data, mem_rd_data;
   logic          div_start, div_done;
   logic [DIV_NW-1:0] div_num;
   logic [DIV_DW-1:0] div_den;
   logic [DIV_QW-1:0] div_quo;

   // combinational helpers
   logic               accept, skip, rd_in_range, last_pix, last_col;
   logic signed [17:0] dx, dy;
   logic [36:0]        d2_sum;
   logic [15:0]        old_ch;
   logic [16:0]        o_fa;

   assign accept      = start && (state_ff == ST_IDLE);
   assign skip        = (req_opacity == '0) || (req_hardness == '0) ||
                        (req_dab_radius < MIN_RADIUS);
   assign rd_in_range = 32'(req_pixel_index) < 32'(NPIX);
   assign last_col    = (32'(x_ff) == 32'(TILE_EDGE - 1));
   assign last_pix    = (32'(idx_ff) == 32'(NPIX - 1));

   // pixel centre minus dab centre
   assign dx = $signed((18'(x_ff) << 8) + 18'd128) - 18'(cx_ff);
   assign dy = $signed((18'(y_ff) << 8) + 18'd128) - 18'(cy_ff);
   assign d2_sum = 37'(dy2_ff) + 37'(dx2_ff);

   always_comb begin
      case (k_ff)
         2'd0:    old_ch = mem_rd_data[63:48];
         2'd1:    old_ch = mem_rd_data[47:32];
         2'd2:    old_ch = mem_rd_data[31:16];
         default: old_ch = mem_rd_data[15:0];
      endcase
   end

   assign o_fa = 17'(rr_ff) + 17'(CH_ONE) - 17'(div_quo);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (last_pix) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) state_in = ST_RDOUT;
               else if (skip) state_in = ST_DONE;
               else state_in = ST_DY;
            end
         end
         ST_RDOUT:  state_in = ST_IDLE;
         ST_DY:     state_in = ST_DX;
         ST_DX:     state_in = ST_CHECK;
         ST_CHECK: begin
            if (d2_sum <= 37'(r2_ff)) state_in = ST_RRGO;
            else if (last_pix) state_in = ST_DONE;
            else if (last_col) state_in = ST_DY;
            else state_in = ST_DX;
         end
         ST_RRGO:   state_in = ST_RRWAIT;
         ST_RRWAIT: if (div_done) state_in = ST_FALL;
         ST_FALL:   state_in = (h_ff == CH_ONE) ? ST_OPA : ST_FWAIT;
         ST_FWAIT:  if (div_done) state_in = ST_OPA;
         ST_OPA:    state_in = ST_OPA2;
         ST_OPA2:   state_in = ST_MA;
         ST_MA:     state_in = ST_MB;
         ST_MB:     state_in = ST_MC;
         ST_MC:     state_in = (k_ff == 2'd3) ? ST_WR : ST_MA;
         ST_WR: begin
            if (last_pix) state_in = ST_DONE;
            else if (last_col) state_in = ST_DY;
            else state_in = ST_DX;
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      rsp_valid_in = 1'b0;
      rsp_r_in     = '0;
      rsp_g_in     = '0;
      rsp_b_in     = '0;
      rsp_a_in     = '0;
      rsp_rd_in    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_IDLE: begin
            mem_rd_en   = accept && req_kind && rd_in_range;
            mem_rd_addr = AW'(req_pixel_index);
         end
         ST_RDOUT: begin
            rsp_valid_in = 1'b1;
            rsp_rd_in    = 1'b1;
            if (rd_ok_ff) begin
               rsp_r_in = mem_rd_data[63:48];
               rsp_g_in = mem_rd_data[47:32];
               rsp_b_in = mem_rd_data[31:16];
               rsp_a_in = mem_rd_data[15:0];
            end
         end
         ST_RRGO: begin
            // rr = round(d2 * ONE / r2)
            mem_rd_en = 1'b1;
            div_start = 1'b1;
            div_num   = (DIV_NW'(d2_ff) << 16) - DIV_NW'(d2_ff) + DIV_NW'(r2_ff >> 1);
            div_den   = r2_ff;
         end
         ST_FALL: begin
            if (h_ff != CH_ONE) begin
               div_start = 1'b1;
               if (rr_ff < h_ff) begin
                  div_num = DIV_NW'(32'(rr_ff) * 32'(CH_ONE)) + DIV_NW'(h_ff >> 1);
                  div_den = DIV_DW'(h_ff);
               end else begin
                  div_num = DIV_NW'(32'(h_ff) * 32'(CH_ONE - rr_ff)) +
                            DIV_NW'((CH_ONE - h_ff) >> 1);
                  div_den = DIV_DW'(CH_ONE - h_ff);
               end
            end
         end
         ST_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {chan_ff[0], chan_ff[1], chan_ff[2], chan_ff[3]};
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_CLEAR: idx_ff <= idx_ff + AW'(1);
            ST_IDLE: begin
               idx_ff <= '0;
               x_ff   <= '0;
               y_ff   <= '0;
            end
            ST_CHECK: begin
               if (d2_sum > 37'(r2_ff) && !last_pix) begin
                  idx_ff <= idx_ff + AW'(1);
                  if (last_col) begin
                     x_ff <= '0;
                     y_ff <= y_ff + XW'(1);
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
               end
            end
            ST_OPA2: k_ff <= '0;
            ST_MC:   k_ff <= k_ff + 2'd1;
            ST_WR: begin
               if (!last_pix) begin
                  idx_ff <= idx_ff + AW'(1);
                  if (last_col) begin
                     x_ff <= '0;
                     y_ff <= y_ff + XW'(1);
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rsp_r_ff  <= rsp_r_in;
      rsp_g_ff  <= rsp_g_in;
      rsp_b_ff  <= rsp_b_in;
      rsp_a_ff  <= rsp_a_in;
      rsp_rd_ff <= rsp_rd_in;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cx_ff     <= req_center_x;
               cy_ff     <= req_center_y;
               r2_ff     <= 30'(req_dab_radius) * 30'(req_dab_radius);
               op_ff     <= req_opacity;
               h_ff      <= req_hardness;
               top_ff[0] <= req_red;
               top_ff[1] <= req_green;
               top_ff[2] <= req_blue;
               top_ff[3] <= CH_ONE;
               rd_ok_ff  <= rd_in_range;
            end
         end
         ST_DY:    dy2_ff <= 36'(dy * dy);
         ST_DX:    dx2_ff <= 36'(dx * dx);
         ST_CHECK: d2_ff  <= d2_sum[29:0];
         ST_RRWAIT: if (div_done) rr_ff <= div_quo;
         ST_FALL: begin
            fa_ff <= rr_ff < h_ff;
            if (h_ff == CH_ONE) o_ff <= CH_ONE;
         end
         ST_FWAIT: if (div_done) o_ff <= fa_ff ? o_fa[15:0] : div_quo;
         ST_OPA:  acc_ff <= 33'(32'(op_ff) * 32'(o_ff)) + 33'(CH_HALF);
         ST_OPA2: opa_ff <= div_one(acc_ff);
         ST_MA:   acc_ff <= 33'(32'(top_ff[k_ff]) * 32'(opa_ff));
         ST_MB:   acc_ff <= acc_ff + 33'(32'(CH_ONE - opa_ff) * 32'(old_ch)) + 33'(CH_HALF);
         ST_MC:   chan_ff[k_ff] <= div_one(acc_ff);
         default: begin
         end
      endcase
   end

   sbd_tile_mem #(
      .DEPTH (NPIX),
      .AW    (AW),
      .DW    (64)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sbd_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_r_ff;
   assign rsp_out_green    = rsp_g_ff;
   assign rsp_out_blue     = rsp_b_ff;
   assign rsp_out_alpha    = rsp_a_ff;
   assign rsp_is_read_data = rsp_rd_ff;
endmodule

// File: tb/tb_soft_brush_dab_tile_blend_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_soft_brush_dab_tile_blend_core
// Drives dab and pixel read commands into the brush core. A scoreboard keeps
// its own copy of the tile, repaints it for every accepted dab and predicts
// every response beat, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_soft_brush_dab_tile_blend_core;
   import sbd_pkg::*;

   localparam int NPIX      = TILE_EDGE_DEF * TILE_EDGE_DEF;
   localparam int N_RANDOM  = 120;
   localparam int MAX_CYC   = 20_000_000;
   localparam logic KIND_DAB  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct {
      logic               kind;
      logic signed [16:0] cx;
      logic signed [16:0] cy;
      logic [14:0]        radius;
      logic [15:0]        opacity;
      logic [15:0]        hardness;
      logic [15:0]        red;
      logic [15:0]        green;
      logic [15:0]        blue;
      logic [11:0]        index;
   } brush_cmd_t;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        is_read;
   } pixel_beat_t;

   // Tile model plus queue of predicted response beats
   class tile_scoreboard;
      logic [15:0] tile_rgb[NPIX][3];
      logic [15:0] tile_alpha[NPIX];
      pixel_beat_t pending_q[$];
      int          errors;

      function new();
         for (int i = 0; i < NPIX; i++) begin
            tile_alpha[i] = '0;
            for (int k = 0; k < 3; k++) tile_rgb[i][k] = '0;
         end
         errors = 0;
      endfunction

      function longint unsigned round_div(longint unsigned n, longint unsigned d);
         return (n + d / 2) / d;
      endfunction

      function longint unsigned mix(longint unsigned top, longint unsigned opa,
                                    longint unsigned old);
         return round_div(top * opa + (65535 - opa) * old, 65535);
      endfunction

      function longint unsigned edge_falloff(longint unsigned rr, longint unsigned h);
         if (h >= 65535) return 65535;
         if (rr < h) return rr + 65535 - round_div(rr * 65535, h);
         return round_div(h * (65535 - rr), 65535 - h);
      endfunction

      function void paint(brush_cmd_t c);
         longint          dx, dy, cxs, cys;
         longint unsigned r2, d2, rr, opa;
         longint unsigned col[3];
         int              idx;
         if (c.opacity == 0 || c.hardness == 0 || c.radius < MIN_RADIUS) return;
         cxs = c.cx;
         cys = c.cy;
         col[0] = c.red;
         col[1] = c.green;
         col[2] = c.blue;
         r2 = longint'(c.radius) * longint'(c.radius);
         for (int yp = 0; yp < TILE_EDGE_DEF; yp++) begin
            dy = yp * 256 + 128 - cys;
            for (int xp = 0; xp < TILE_EDGE_DEF; xp++) begin
               dx = xp * 256 + 128 - cxs;
               d2 = dx * dx + dy * dy;
               if (d2 <= r2) begin
                  rr  = round_div(d2 * 65535, r2);
                  opa = round_div(longint'(c.opacity) * edge_falloff(rr, c.hardness),
                                  65535);
                  idx = yp * TILE_EDGE_DEF + xp;
                  tile_alpha[idx] = 16'(mix(65535, opa, tile_alpha[idx]));
                  for (int k = 0; k < 3; k++)
                     tile_rgb[idx][k] = 16'(mix(col[k], opa, tile_rgb[idx][k]));
               end
            end
         end
      endfunction

      // Accepted command: update the tile and queue the beat it will return
      function void note_request(brush_cmd_t c);
         pixel_beat_t b;
         b = '{default: '0};
         if (c.kind == KIND_DAB) begin
            paint(c);
         end else begin
            b.is_read = 1'b1;
            if (c.index < NPIX) begin
               b.red   = tile_rgb[c.index][0];
               b.green = tile_rgb[c.index][1];
               b.blue  = tile_rgb[c.index][2];
               b.alpha = tile_alpha[c.index];
            end
         end
         pending_q.push_back(b);
      endfunction

      function void check_beat(pixel_beat_t got);
         pixel_beat_t want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat at %0t", $time);
            return;
         end
         want = pending_q.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
             || got.alpha !== want.alpha || got.is_read !== want.is_read) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: exp r%h g%h b%h a%h rd%b got r%h g%h b%h a%h rd%b",
                        $time, want.red, want.green, want.blue, want.alpha, want.is_read,
                        got.red, got.green, got.blue, got.alpha, got.is_read);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = 1'b0;
   logic signed [16:0] req_center_x = '0;
   logic signed [16:0] req_center_y = '0;
   logic [14:0]        req_dab_radius = '0;
   logic [15:0]        req_opacity = '0;
   logic [15:0]        req_hardness = '0;
   logic [15:0]        req_red = '0;
   logic [15:0]        req_green = '0;
   logic [15:0]        req_blue = '0;
   logic [11:0]        req_pixel_index = '0;
   logic               rsp_valid;
   logic [15:0]        rsp_out_red;
   logic [15:0]        rsp_out_green;
   logic [15:0]        rsp_out_blue;
   logic [15:0]        rsp_out_alpha;
   logic               rsp_is_read_data;

   tile_scoreboard     sb = new();
   int                 cycles = 0;
   int                 idle_pct = 0;
   brush_cmd_t         last_dab;

   soft_brush_dab_tile_blend_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_dab_radius   (req_dab_radius),
      .req_opacity      (req_opacity),
      .req_hardness     (req_hardness),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_pixel_index  (req_pixel_index),
      .rsp_valid        (rsp_valid),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_is_read_data (rsp_is_read_data)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_beat('{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
                         rsp_is_read_data});
   end

   // Present one command beat and hold it until accepted, then maybe idle
   task automatic send(brush_cmd_t c);
      start           <= 1'b1;
      req_kind        <= c.kind;
      req_center_x    <= c.cx;
      req_center_y    <= c.cy;
      req_dab_radius  <= c.radius;
      req_opacity     <= c.opacity;
      req_hardness    <= c.hardness;
      req_red         <= c.red;
      req_green       <= c.green;
      req_blue        <= c.blue;
      req_pixel_index <= c.index;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(c);
      if (c.kind == KIND_DAB) last_dab = c;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic brush_cmd_t make_dab(int cx, int cy, int rad, int op, int h);
      brush_cmd_t c;
      c.kind     = KIND_DAB;
      c.cx       = 17'(cx);
      c.cy       = 17'(cy);
      c.radius   = 15'(rad);
      c.opacity  = 16'(op);
      c.hardness = 16'(h);
      c.red      = 16'($urandom);
      c.green    = 16'($urandom);
      c.blue     = 16'($urandom);
      c.index    = 12'($urandom);
      return c;
   endfunction

   function automatic brush_cmd_t make_read(int idx);
      brush_cmd_t c;
      c = make_dab($urandom, $urandom, $urandom, $urandom, $urandom);
      c.kind  = KIND_READ;
      c.index = 12'(idx);
      return c;
   endfunction

   // Read a pixel near the center of the last dab
   function automatic int near_last_dab();
      int px, py;
      px = (int'(last_dab.cx) >>> 8) + $urandom_range(8) - 4;
      py = (int'(last_dab.cy) >>> 8) + $urandom_range(8) - 4;
      px = px < 0 ? 0 : (px > 63 ? 63 : px);
      py = py < 0 ? 0 : (py > 63 ? 63 : py);
      return py * TILE_EDGE_DEF + px;
   endfunction

   initial begin
      brush_cmd_t c;
      int         pct[4];

      pct = '{0, 45, 0, 38};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: cleared tile, hard/soft/mid edges, skips, edges of the fields
      send(make_read(0));
      send(make_read(NPIX - 1));
      c = make_dab(10 * 256 + 128, 10 * 256 + 128, 1280, 65535, 65535);
      c.red = 16'hFFFF; c.green = 16'h0000; c.blue = 16'h8000;
      send(c);
      send(make_read(10 * 64 + 10));
      send(make_read(10 * 64 + 14));
      send(make_dab(20 * 256 + 128, 20 * 256, 1800, 40000, 1));
      send(make_read(20 * 64 + 21));
      send(make_dab(30 * 256, 30 * 256, 2000, 1, 32768));
      send(make_read(29 * 64 + 30));
      send(make_dab(40 * 256 + 128, 40 * 256 + 128, 26, 65535, 65535));
      send(make_read(40 * 64 + 40));
      send(make_dab(40 * 256, 40 * 256, 25, 65535, 65535));
      send(make_dab(40 * 256, 40 * 256, 3000, 0, 65535));
      send(make_dab(40 * 256, 40 * 256, 3000, 65535, 0));
      send(make_read(40 * 64 + 40));
      send(make_dab(-32768, -32768, 32767, 65535, 65534));
      send(make_dab(49151, 49151, 4000, 65535, 50000));
      send(make_read(NPIX - 1));
      send(make_dab(-65536, 65535, 32767, 20000, 65535));
      send(make_dab(0, 0, 32767, 32768, 40000));
      send(make_read(0));
      send(make_read(2080));
      send(make_read(NPIX - 1));

      // Random: mostly small dabs followed by reads around them
      for (int n = 0; n < N_RANDOM; n++) begin
         idle_pct = pct[(n * 4) / N_RANDOM];
         if ($urandom_range(99) < 30) begin
            case ($urandom_range(19))
               0:       c = make_dab($urandom, $urandom, $urandom, $urandom, $urandom);
               1:       c = make_dab($urandom_range(81919) - 32768,
                                     $urandom_range(81919) - 32768,
                                     $urandom_range(32767, 16384),
                                     $urandom, $urandom);
               2:       c = make_dab($urandom_range(16383), $urandom_range(16383),
                                     $urandom_range(30), 0, $urandom);
               default: c = make_dab($urandom_range(16639) - 256,
                                     $urandom_range(16639) - 256,
                                     $urandom_range(1536, 26),
                                     $urandom_range(65535, 1), $urandom_range(65535, 1));
            endcase
            send(c);
         end else if ($urandom_range(99) < 65) begin
            send(make_read(near_last_dab()));
         end else begin
            send(make_read($urandom));
         end
      end

      start <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      sb.errors += sb.pending_q.size();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
